// ===== rtl/tiht_pkg.sv =====
// Package for the tag interning hash table.
// Holds the status codes, the result widths and the preloaded ROOT name.
// No dependencies.
package tiht_pkg;

    localparam int TAG_ID_W = 10;
    localparam int STATUS_W = 3;

    typedef logic [TAG_ID_W-1:0] t_tag_id;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_FOUND     = 3'd0;
    localparam t_status ST_INSERTED  = 3'd1;
    localparam t_status ST_FULL      = 3'd2;
    localparam t_status ST_TOO_LONG  = 3'd3;
    localparam t_status ST_EXHAUSTED = 3'd4;

    localparam int ROOT_LEN = 4;
    localparam logic [7:0] ROOT_NAME [ROOT_LEN] = '{8'd82, 8'd79, 8'd79, 8'd84};
    localparam int ROOT_SUM = 82 + 79 + 79 + 84;

endpackage

// ===== rtl/tiht_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tiht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/tag_interning_hash_table_top.sv =====
// Top level of the tag interning hash table: gathering, bucket scan and insertion.
// Depends on tiht_pkg and tiht_ram.
//
//  channel  | valid   | stall   | payload
//  ---------+---------+---------+------------------------------------------
//  input    | i_valid | o_stall | i_tag_byte, i_skip_byte, i_last_byte
//  output   | o_valid | i_stall | o_tag_id, o_status
//
// A word that is not the last of a tag is gathered. A last word starts the lookup:
// the bucket fill is fetched, then per stored way the length is read and compared,
// and on a match the bytes one by one; for an insertion each stored byte is copied.
// The bucket fill memory and the single read ports of the entry memories pace this.
// After reset a clearing pass clears the fill memory and preloads ROOT as id 0; no
// word is taken meanwhile. A stalled result is held in the output register while
// the next tag's bytes are gathered.
module tag_interning_hash_table_top #(
    parameter int NUM_BUCKETS = 64,
    parameter int BUCKET_WAYS = 4,
    parameter int MAX_TAG_LEN = 32,
    parameter int MAX_TAGS    = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_tag_byte,
    input  logic              i_skip_byte,
    input  logic              i_last_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output tiht_pkg::t_tag_id o_tag_id,
    output tiht_pkg::t_status o_status
);
    import tiht_pkg::*;

    // Widths derived from the parameters.
    localparam int SW    = $clog2(NUM_BUCKETS);
    localparam int SLOTS = NUM_BUCKETS * BUCKET_WAYS;
    localparam int SLW   = SLOTS > 1 ? $clog2(SLOTS) : 1;
    localparam int CHARS = SLOTS * MAX_TAG_LEN;
    localparam int CAW   = $clog2(CHARS);
    localparam int LW    = $clog2(MAX_TAG_LEN + 1);
    localparam int GAW   = $clog2(MAX_TAG_LEN);
    localparam int FW    = $clog2(BUCKET_WAYS + 1);
    localparam int MIW   = $clog2(MAX_TAGS);
    localparam int NIW   = $clog2(MAX_TAGS + 1);
    localparam int MW    = LW + MIW;
    localparam int INIT_LEN = NUM_BUCKETS > ROOT_LEN ? NUM_BUCKETS : ROOT_LEN;
    localparam int ICW   = $clog2(INIT_LEN + 1);
    localparam int ROOT_BKT  = ROOT_SUM % NUM_BUCKETS;
    localparam int ROOT_SLOT = ROOT_BKT * BUCKET_WAYS;
    localparam int ROOT_CADDR = ROOT_SLOT * MAX_TAG_LEN;

    // Controller states.
    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_GATHER = 4'd1;
    localparam logic [3:0] S_FWAIT  = 4'd2;
    localparam logic [3:0] S_FGET   = 4'd3;
    localparam logic [3:0] S_META   = 4'd4;
    localparam logic [3:0] S_MRD    = 4'd5;
    localparam logic [3:0] S_MCHK   = 4'd6;
    localparam logic [3:0] S_CRD    = 4'd7;
    localparam logic [3:0] S_CCHK   = 4'd8;
    localparam logic [3:0] S_DECIDE = 4'd9;
    localparam logic [3:0] S_CPRD   = 4'd10;
    localparam logic [3:0] S_CPWR   = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic [3:0]     r_state, n_state;
    logic [ICW-1:0] r_init, n_init;
    logic [LW-1:0]  r_len, n_len;
    logic [SW-1:0]  r_sum, n_sum;
    logic           r_ov, n_ov;
    logic [FW-1:0]  r_fill, n_fill;
    logic [FW-1:0]  r_w, n_w;
    logic [SLW-1:0] r_slot, n_slot;
    logic [GAW-1:0] r_k, n_k;
    logic [MIW-1:0] r_mid, n_mid;
    logic [NIW-1:0] r_next, n_next;
    logic [NIW-1:0] r_res_id, n_res_id;
    t_status        r_res_st, n_res_st;
    logic           r_ovalid, n_ovalid;
    t_tag_id        r_oid, n_oid;
    t_status        r_ost, n_ost;

    // Memory ports.
    logic           g_we;
    logic [GAW-1:0] g_waddr;
    logic [7:0]     g_rdata;
    logic           f_we;
    logic [SW-1:0]  f_waddr;
    logic [FW-1:0]  f_wdata, f_rdata;
    logic           m_we;
    logic [SLW-1:0] m_waddr;
    logic [MW-1:0]  m_wdata, m_rdata;
    logic           c_we;
    logic [CAW-1:0] c_waddr, c_raddr;
    logic [7:0]     c_wdata, c_rdata;

    logic [SW-1:0]  w_byte_mod [256];
    logic [SW:0]    w_sum_add;
    logic           w_accept, w_kept, w_out_free;
    logic [SLW-1:0] w_ins_slot, w_scan_slot;

    // Byte value modulo the bucket count, worked out at elaboration.
    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign w_byte_mod[g] = SW'(g % NUM_BUCKETS);
    end

    tiht_ram #(.WIDTH(8), .DEPTH(MAX_TAG_LEN)) u_gather (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(g_waddr), .i_wdata(i_tag_byte),
        .i_raddr(r_k), .o_rdata(g_rdata)
    );
    tiht_ram #(.WIDTH(FW), .DEPTH(NUM_BUCKETS)) u_fill (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(f_waddr), .i_wdata(f_wdata),
        .i_raddr(r_sum), .o_rdata(f_rdata)
    );
    tiht_ram #(.WIDTH(MW), .DEPTH(SLOTS)) u_meta (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(m_wdata),
        .i_raddr(r_slot), .o_rdata(m_rdata)
    );
    tiht_ram #(.WIDTH(8), .DEPTH(CHARS)) u_chars (
        .i_clk(i_clk), .i_we(c_we), .i_waddr(c_waddr), .i_wdata(c_wdata),
        .i_raddr(c_raddr), .o_rdata(c_rdata)
    );

    assign o_stall    = (r_state != S_GATHER);
    assign w_accept   = i_valid && !o_stall;
    assign w_kept     = !i_skip_byte;
    assign w_out_free = !r_ovalid || !i_stall;
    assign w_sum_add  = {1'b0, r_sum} + {1'b0, w_byte_mod[i_tag_byte]};
    assign w_scan_slot = SLW'(r_sum) * SLW'(BUCKET_WAYS) + SLW'(r_w);
    assign w_ins_slot  = SLW'(r_sum) * SLW'(BUCKET_WAYS) + SLW'(r_fill);
    assign c_raddr = CAW'(r_slot) * CAW'(MAX_TAG_LEN) + CAW'(r_k);
    assign g_waddr = r_len[GAW-1:0];

    always_comb begin
        n_state = r_state;  n_init = r_init;  n_len = r_len;  n_sum = r_sum;
        n_ov = r_ov;  n_fill = r_fill;  n_w = r_w;  n_slot = r_slot;  n_k = r_k;
        n_mid = r_mid;  n_next = r_next;  n_res_id = r_res_id;  n_res_st = r_res_st;
        n_ovalid = r_ovalid;  n_oid = r_oid;  n_ost = r_ost;
        g_we = 1'b0;
        f_we = 1'b0;  f_waddr = r_init[SW-1:0];  f_wdata = '0;
        m_we = 1'b0;  m_waddr = w_ins_slot;
        m_wdata = {LW'(r_len), MIW'(r_next)};
        c_we = 1'b0;  c_waddr = c_raddr;  c_wdata = g_rdata;

        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                // Clearing pass over the fill memory, with ROOT written alongside.
                if (r_init < ICW'(NUM_BUCKETS)) begin
                    f_we    = 1'b1;
                    f_wdata = (r_init == ICW'(ROOT_BKT)) ? FW'(1) : FW'(0);
                end
                if (r_init < ICW'(ROOT_LEN)) begin
                    c_we    = 1'b1;
                    c_waddr = CAW'(ROOT_CADDR) + CAW'(r_init);
                    c_wdata = ROOT_NAME[r_init[1:0]];
                end
                if (r_init == '0) begin
                    m_we    = 1'b1;
                    m_waddr = SLW'(ROOT_SLOT);
                    m_wdata = {LW'(ROOT_LEN), MIW'(0)};
                end
                n_init = r_init + 1'b1;
                if (r_init == ICW'(INIT_LEN - 1)) begin
                    n_state = S_GATHER;
                end
            end
            S_GATHER: begin
                if (w_accept) begin
                    if (w_kept) begin
                        if (r_len < LW'(MAX_TAG_LEN)) begin
                            g_we  = 1'b1;
                            n_len = r_len + 1'b1;
                        end else begin
                            n_ov = 1'b1;
                        end
                        n_sum = (w_sum_add >= (SW+1)'(NUM_BUCKETS))
                              ? SW'(w_sum_add - (SW+1)'(NUM_BUCKETS)) : SW'(w_sum_add);
                    end
                    if (i_last_byte) begin
                        n_state = S_FWAIT;
                    end
                end
            end
            S_FWAIT: n_state = S_FGET;
            S_FGET: begin
                n_fill = f_rdata;
                n_w    = '0;
                if (r_ov) begin
                    n_res_id = '0;  n_res_st = ST_TOO_LONG;  n_state = S_DONE;
                end else begin
                    n_state = S_META;
                end
            end
            S_META: begin
                if (r_w < r_fill) begin
                    n_slot  = w_scan_slot;
                    n_state = S_MRD;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_MRD: n_state = S_MCHK;
            S_MCHK: begin
                n_mid = m_rdata[MIW-1:0];
                if (m_rdata[MW-1:MIW] == r_len) begin
                    if (r_len == '0) begin
                        n_res_id = NIW'(m_rdata[MIW-1:0]);
                        n_res_st = ST_FOUND;
                        n_state  = S_DONE;
                    end else begin
                        n_k = '0;  n_state = S_CRD;
                    end
                end else begin
                    n_w = r_w + 1'b1;  n_state = S_META;
                end
            end
            S_CRD: n_state = S_CCHK;
            S_CCHK: begin
                if (c_rdata != g_rdata) begin
                    n_w = r_w + 1'b1;  n_state = S_META;
                end else if (LW'(r_k) == r_len - 1'b1) begin
                    n_res_id = NIW'(r_mid);  n_res_st = ST_FOUND;  n_state = S_DONE;
                end else begin
                    n_k = r_k + 1'b1;  n_state = S_CRD;
                end
            end
            S_DECIDE: begin
                n_res_id = '0;
                if (r_fill >= FW'(BUCKET_WAYS)) begin
                    n_res_st = ST_FULL;  n_state = S_DONE;
                end else if (r_next >= NIW'(MAX_TAGS)) begin
                    n_res_st = ST_EXHAUSTED;  n_state = S_DONE;
                end else begin
                    m_we     = 1'b1;
                    f_we     = 1'b1;
                    f_waddr  = r_sum;
                    f_wdata  = r_fill + 1'b1;
                    n_slot   = w_ins_slot;
                    n_k      = '0;
                    n_res_id = r_next;
                    n_res_st = ST_INSERTED;
                    n_next   = r_next + 1'b1;
                    n_state  = (r_len == '0) ? S_DONE : S_CPRD;
                end
            end
            S_CPRD: n_state = S_CPWR;
            S_CPWR: begin
                c_we = 1'b1;
                if (LW'(r_k) == r_len - 1'b1) begin
                    n_state = S_DONE;
                end else begin
                    n_k = r_k + 1'b1;  n_state = S_CPRD;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_oid    = TAG_ID_W'(32'(r_res_id));
                    n_ost    = r_res_st;
                    n_len    = '0;
                    n_sum    = '0;
                    n_ov     = 1'b0;
                    n_state  = S_GATHER;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_init   <= '0;
            r_len    <= '0;
            r_sum    <= '0;
            r_ov     <= 1'b0;
            r_next   <= NIW'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_init   <= n_init;
            r_len    <= n_len;
            r_sum    <= n_sum;
            r_ov     <= n_ov;
            r_next   <= n_next;
            r_ovalid <= n_ovalid;
        end
        r_fill   <= n_fill;
        r_w      <= n_w;
        r_slot   <= n_slot;
        r_k      <= n_k;
        r_mid    <= n_mid;
        r_res_id <= n_res_id;
        r_res_st <= n_res_st;
        r_oid    <= n_oid;
        r_ost    <= n_ost;
    end

    assign o_valid  = r_ovalid;
    assign o_tag_id = r_oid;
    assign o_status = r_ost;

    // An insertion only ever writes into a bucket that still has a free way.
    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && m_we) |-> (r_fill < FW'(BUCKET_WAYS)))
        else $error("insertion into a full bucket");

    // Error results carry id zero.
    a_err_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_FOUND && o_status != ST_INSERTED) |-> (o_tag_id == '0))
        else $error("error result with non-zero id");

    // The id counter never passes the id space.
    a_next_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next <= NIW'(MAX_TAGS)) && (r_next != '0))
        else $error("id counter out of range");

    // A new result is only loaded when the output register is free.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_tag_id) && $stable(o_status)))
        else $error("stalled result overwritten");
endmodule
